>>> src/keyed_slot_allocator_assert.svh
// Assertion macros for the keyed slot allocator.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef KEYED_SLOT_ALLOCATOR_ASSERT_SVH
`define KEYED_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every edge.
`define KSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequence holds on the edge after the trigger.
`define KSA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);
// Consequence holds on the same edge as the trigger.
`define KSA_ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);
`else
`define KSA_ASSERT_ALWAYS(lbl, cond, msg)
`define KSA_ASSERT_NEXT(lbl, trig, cons, msg)
`define KSA_ASSERT_SAME(lbl, trig, cons, msg)
`endif
`endif

>>> src/ksa_pkg.sv
`default_nettype none
package ksa_pkg;

  // Fixed field widths of the item and result
  localparam int unsigned KEY_FIELD_W  = 64;
  localparam int unsigned SIZE_FIELD_W = 16;
  localparam int unsigned STATUS_W     = 4;
  localparam int unsigned INDEX_W      = 4;

  // Opcodes
  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 4'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BIG      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FULL     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOTREADY = 4'd8;

  typedef struct packed {
    logic                    opcode;
    logic [KEY_FIELD_W-1:0]  slot_key;
    logic [SIZE_FIELD_W-1:0] block_size;
  } ksa_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot_index;
  } ksa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch item, reset scan
    logic step;    // read one slot, advance
    logic finish;  // commit table update, load result
  } ksa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pre_fail;  // item fails before any scan
    logic hit;       // compare stage found the key
    logic last;      // scan pointer is at the last slot
    logic out_free;  // result register can take a result
  } ksa_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } ksa_state_t;

endpackage
`default_nettype wire

>>> src/ksa_ctrl.sv
`default_nettype none
module ksa_ctrl import ksa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ksa_stat_t stat,
  output ksa_cmd_t       cmd
);

  ksa_state_t state_r;
  ksa_state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.pre_fail || stat.hit) begin
          state_nxt = S_FINISH;
        end else if (stat.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.step = !stat.pre_fail && !stat.hit;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/ksa_dp.sv
`default_nettype none
module ksa_dp import ksa_pkg::*; #(
  parameter int SLOTS          = 16,
  parameter int MAX_BLOCK_SIZE = 256,
  parameter int KEY_BYTES      = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ksa_in_t  in_data,
  input  wire logic     cfg_valid,
  input  wire logic     cfg_region_ready,
  input  wire ksa_cmd_t cmd,
  output ksa_stat_t     stat,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ksa_out_t      out_data
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int SIZE_W = $clog2(MAX_BLOCK_SIZE + 1);

  logic                  region_ready_r;
  ksa_in_t               req_r;
  logic [SLOTS-1:0]      occ_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  cmp_vld_r;
  logic                  cmp_occ_r;
  logic [KEY_W-1:0]      rd_key_r;
  logic [SIZE_W-1:0]     rd_size_r;
  logic                  found_r;
  logic [IDX_W-1:0]      found_idx_r;
  logic [SIZE_W-1:0]     found_size_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  out_valid_r;
  ksa_out_t              out_data_r;

  logic [KEY_W-1:0]      key_mem [SLOTS];
  logic [SIZE_W-1:0]     size_mem [SLOTS];

  logic [KEY_W-1:0]      req_key;
  logic                  size_zero;
  logic                  size_big;
  logic                  hit;
  logic                  do_alloc;
  logic                  do_release;
  ksa_out_t              res;

  // Slot number as seen on the result, kept modulo the field range
  function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] i);
    logic [IDX_W+INDEX_W-1:0] w;
    w = (IDX_W + INDEX_W)'(i);
    return w[INDEX_W-1:0];
  endfunction

  assign req_key   = req_r.slot_key[KEY_W-1:0];
  assign size_zero = (req_r.block_size == '0);
  assign size_big  = (req_r.block_size > SIZE_FIELD_W'(MAX_BLOCK_SIZE));
  assign hit       = cmp_vld_r && cmp_occ_r && (rd_key_r == req_key);

  // Status to the controller
  always_comb begin
    stat.hit      = hit;
    stat.last     = (idx_r == IDX_W'(SLOTS - 1));
    stat.out_free = !out_valid_r || out_ready;
    if (req_r.opcode == OP_RELEASE) begin
      stat.pre_fail = !region_ready_r;
    end else begin
      stat.pre_fail = size_zero || size_big || !region_ready_r;
    end
  end

  // Decide the result and the table update
  always_comb begin
    res        = '0;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    if (req_r.opcode == OP_RELEASE) begin
      if (!region_ready_r) begin
        res.status = ST_NOTREADY;
      end else if (found_r) begin
        res.status     = ST_RELEASED;
        res.slot_index = to_index(found_idx_r);
        do_release     = 1'b1;
      end else begin
        res.status = ST_NOMATCH;
      end
    end else if (size_zero) begin
      res.status = ST_ZERO;
    end else if (size_big) begin
      res.status = ST_BIG;
    end else if (!region_ready_r) begin
      res.status = ST_NOTREADY;
    end else if (found_r) begin
      res.slot_index = to_index(found_idx_r);
      if (SIZE_FIELD_W'(found_size_r) != req_r.block_size) begin
        res.status = ST_MISMATCH;
      end else begin
        res.status = ST_FOUND;
      end
    end else if (free_found_r) begin
      res.status     = ST_ALLOC;
      res.slot_index = to_index(free_idx_r);
      do_alloc       = 1'b1;
    end else begin
      res.status = ST_FULL;
    end
  end

  // Configuration register and slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_ready_r <= 1'b0;
      occ_r          <= '0;
    end else begin
      if (cfg_valid) region_ready_r <= cfg_region_ready;
      if (cmd.finish && do_alloc) occ_r[free_idx_r] <= 1'b1;
      if (cmd.finish && do_release) occ_r[found_idx_r] <= 1'b0;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.start) req_r <= in_data;
  end

  // Scan pointer and compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.start) begin
      idx_r        <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.step;
      if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
        if (!occ_r[idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (hit && !found_r) found_r <= 1'b1;
    end
  end

  // Capture slot numbers and the matched size
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cmp_idx_r <= idx_r;
      cmp_occ_r <= occ_r[idx_r];
      if (!occ_r[idx_r] && !free_found_r) free_idx_r <= idx_r;
    end
    if (hit && !found_r) begin
      found_idx_r  <= cmp_idx_r;
      found_size_r <= rd_size_r;
    end
  end

  // Key and size memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.finish && do_alloc) begin
      key_mem[free_idx_r]  <= req_key;
      size_mem[free_idx_r] <= SIZE_W'(req_r.block_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_key_r  <= key_mem[idx_r];
      rd_size_r <= size_mem[idx_r];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> src/keyed_slot_allocator.sv
`default_nettype none
`include "keyed_slot_allocator_assert.svh"
// Keyed slot allocator: a table of SLOTS named slots, each holding a key of
// KEY_BYTES bytes and a block size. A get item returns the first occupied
// slot whose key matches (or a size mismatch), else claims the first empty
// slot, else reports full; a release item empties the first matching slot.
// Each item gives one result. The block works on one item at a time: the
// controller scans the key/size memory one slot per cycle through its single
// registered read port; an item's scan ends when a match stops it early or
// after the last slot is read, and none runs when the size or region checks
// fail. A finished result waits in an output register while
// the next item is accepted. Reset empties every slot at once through
// per-slot occupancy bits; no clearing pass is needed. region_ready is
// written over the cfg_ port and must change only while no item is in work.
module keyed_slot_allocator import ksa_pkg::*; #(
  parameter int SLOTS          = 16,
  parameter int MAX_BLOCK_SIZE = 256,
  parameter int KEY_BYTES      = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire ksa_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output ksa_out_t     out_data,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire logic    cfg_region_ready
);

  ksa_cmd_t  cmd;
  ksa_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  ksa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksa_dp #(
    .SLOTS          (SLOTS),
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE),
    .KEY_BYTES      (KEY_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_region_ready (cfg_region_ready),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  // One item in work at a time
  `KSA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  // Status codes stay in range
  `KSA_ASSERT_SAME(a_status_range, out_valid, out_data.status <= ST_NOTREADY, "bad status")
  // Failures without a slot report slot zero
  `KSA_ASSERT_SAME(a_zero_index, out_valid && (out_data.status == ST_NOMATCH || out_data.status == ST_ZERO || out_data.status == ST_BIG || out_data.status == ST_FULL || out_data.status == ST_NOTREADY), out_data.slot_index == '0, "nonzero slot on failure")
  // A result never comes out in the cycle after its item is taken
  `KSA_ASSERT_NEXT(a_min_latency, in_valid && in_ready && !out_valid, !out_valid, "result too early")

endmodule
`default_nettype wire
